[hdl/quadratic_bezier_crossfade_gain_defines.svh]
// assertion helpers shared by the crossfade gain rtl
`ifndef QUADRATIC_BEZIER_CROSSFADE_GAIN_DEFINES_SVH
`define QUADRATIC_BEZIER_CROSSFADE_GAIN_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QBCG_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qbcg assertion failed");

// next-cycle implication, checked out of reset
`define QBCG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qbcg assertion failed");

`endif

[hdl/qbcg_pkg.sv]
`timescale 1ns / 1ps
package qbcg_pkg;
	localparam int FRAC_BITS = 16;
	localparam int ONE_W = FRAC_BITS + 1;
	localparam int CP_W = 16;
	localparam int IDX_W = 1;
	localparam int D_W = 2 * FRAC_BITS;
	localparam int ROOT_W = FRAC_BITS;
	localparam int REM_W = D_W + 2;
	localparam int DEN_W = ONE_W;
	localparam int NUM_W = ONE_W + FRAC_BITS;
	localparam int QUO_W = 22;
	localparam int DSH_W = DEN_W + QUO_W;
	localparam int MUL_W = 2 * ONE_W;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;
	localparam logic [ONE_W-1:0] HALF = ONE_W'(1) << (FRAC_BITS - 1);
	localparam logic [CP_W-1:0] LO_CLAMP = CP_W'(((1 << FRAC_BITS) * 5 + 50) / 100);
	localparam logic [CP_W-1:0] HI_CLAMP = CP_W'((1 << FRAC_BITS) - ((1 << FRAC_BITS) * 5 + 50) / 100);
	localparam logic [CP_W-1:0] CP_RESET = CP_W'(1 << (FRAC_BITS - 1));

	typedef enum logic [IDX_W-1:0] {
		REG_CONTROL_X = 1'b0,
		REG_CONTROL_Y = 1'b1
	} reg_idx_t;

	// queue entry: clamped discriminant and saturated position
	typedef struct packed {
		logic [D_W-1:0] disc;
		logic [ONE_W-1:0] x;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [CP_W-1:0] clamp_cp(input logic [CP_W-1:0] v);
		logic [CP_W-1:0] r;
		if (v < LO_CLAMP) r = LO_CLAMP;
		else if (v > HI_CLAMP) r = HI_CLAMP;
		else r = v;
		return r;
	endfunction
endpackage

[hdl/qbcg_if.sv]
`timescale 1ns / 1ps
interface qbcg_pos_if;
	import qbcg_pkg::*;
	logic valid;
	logic ready;
	logic [ONE_W-1:0] position;
	modport source(output valid, output position, input ready);
	modport sink(input valid, input position, output ready);
endinterface

interface qbcg_gain_if;
	import qbcg_pkg::*;
	logic valid;
	logic ready;
	logic [ONE_W-1:0] fade_in_gain;
	logic [ONE_W-1:0] fade_out_gain;
	modport source(output valid, output fade_in_gain, output fade_out_gain, input ready);
	modport sink(input valid, input fade_in_gain, input fade_out_gain, output ready);
endinterface

[hdl/quadratic_bezier_crossfade_gain.sv]
`timescale 1ns / 1ps
// Crossfade gain curve: maps a Q16 position x to the fade-in gain y of a
// quadratic Bezier from (0,0) through (control_x, control_y) to (1,1), and
// gives 1-y as the fade-out gain. One position is taken every cycle; an item
// passes the 16-stage square root and then the 22-stage divider, one bit
// per stage, on its way from its transfer in to its result. A
// four-entry queue sits between the front (position saturate, discriminant)
// and the back (root, divide, polynomial), so a stalled output only backs up
// the input once the queue is full. Control points are clamped to 0.05..0.95
// on write and should only be written while no item is in flight.
`include "quadratic_bezier_crossfade_gain_defines.svh"
module quadratic_bezier_crossfade_gain #(
	parameter int QUEUE_DEPTH = qbcg_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	qbcg_pos_if.sink                     pos_chan,
	qbcg_gain_if.source                  gain_chan,
	input  logic                         cfg_we,
	input  logic [qbcg_pkg::IDX_W-1:0]   cfg_index,
	input  logic [qbcg_pkg::CP_W-1:0]    cfg_data
);
	import qbcg_pkg::*;

	// control point registers
	logic [CP_W-1:0] cx_q;
	logic [CP_W-1:0] cy_q;

	// front to queue to back
	logic push;
	logic pop;
	work_t push_data;
	work_t head;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= CP_RESET;
			cy_q <= CP_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CONTROL_X: cx_q <= clamp_cp(cfg_data);
				REG_CONTROL_Y: cy_q <= clamp_cp(cfg_data);
				default: ;
			endcase
		end
	end

	// front: saturate position, form the discriminant
	qbcg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_chan  (pos_chan),
		.cx        (cx_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	qbcg_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// back: root, divide, curve value
	qbcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.cx        (cx_q),
		.cy        (cy_q),
		.gain_chan (gain_chan)
	);

	// control points always stay inside the clamp window
	`QBCG_ASSERT(a_cx_range, 1'b1, (cx_q >= LO_CLAMP) && (cx_q <= HI_CLAMP))
	`QBCG_ASSERT(a_cy_range, 1'b1, (cy_q >= LO_CLAMP) && (cy_q <= HI_CLAMP))
	// gains always sum to one
	`QBCG_ASSERT(a_gain_sum, gain_chan.valid, (gain_chan.fade_in_gain + gain_chan.fade_out_gain) == ONE)
endmodule

[hdl/qbcg_front.sv]
`timescale 1ns / 1ps
module qbcg_front (
	input  logic                        clk,
	input  logic                        arst_n,
	qbcg_pos_if.sink                    pos_chan,
	input  logic [qbcg_pkg::CP_W-1:0]   cx,
	input  qbcg_pkg::q_stat_t           q_stat,
	output logic                        push,
	output qbcg_pkg::work_t             push_data
);
	import qbcg_pkg::*;

	logic [ONE_W-1:0] x_sat;
	logic signed [ONE_W:0] a_coef;
	logic signed [2*ONE_W+1:0] ax;
	logic [D_W-1:0] cxsq_q;
	logic valid_s1;
	logic signed [2*ONE_W+1:0] ax_s1;
	logic [ONE_W-1:0] x_s1;
	logic signed [2*ONE_W+2:0] dsum;
	logic take;

	assign pos_chan.ready = !valid_s1 || !q_stat.full;
	assign take = pos_chan.valid && pos_chan.ready;
	assign x_sat = (pos_chan.position > ONE) ? ONE : pos_chan.position;
	assign a_coef = $signed({1'b0, ONE}) - $signed({1'b0, cx, 1'b0});
	assign ax = (2*ONE_W+2)'(a_coef) * (2*ONE_W+2)'($signed({1'b0, x_sat}));

	// cx squared follows the register; config must only change while idle, which the block does not enforce
	always_ff @(posedge clk) begin
		cxsq_q <= D_W'(cx) * D_W'(cx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pos_chan.ready) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ax_s1 <= ax;
			x_s1 <= x_sat;
		end
	end

	// discriminant, negative clamps to zero
	assign dsum = $signed({3'b0, cxsq_q}) + (2*ONE_W+3)'(ax_s1);
	assign push = valid_s1 && !q_stat.full;
	assign push_data.disc = dsum[2*ONE_W+2] ? '0 : dsum[D_W-1:0];
	assign push_data.x = x_s1;
endmodule

[hdl/qbcg_fifo.sv]
`timescale 1ns / 1ps
`include "quadratic_bezier_crossfade_gain_defines.svh"
module qbcg_fifo #(
	parameter int DEPTH = qbcg_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qbcg_pkg::work_t   push_data,
	input  logic              pop,
	output qbcg_pkg::work_t   head,
	output qbcg_pkg::q_stat_t stat
);
	import qbcg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head = mem_q[rd_ptr_q];
	assign stat.full = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`QBCG_ASSERT(a_no_overflow, push && stat.full, pop)
	`QBCG_ASSERT(a_no_underflow, pop, !stat.empty)
	`QBCG_ASSERT_NXT(a_count_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

[hdl/qbcg_back.sv]
`timescale 1ns / 1ps
module qbcg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qbcg_pkg::work_t             head,
	input  qbcg_pkg::q_stat_t           q_stat,
	output logic                        pop,
	input  logic [qbcg_pkg::CP_W-1:0]   cx,
	input  logic [qbcg_pkg::CP_W-1:0]   cy,
	qbcg_gain_if.source                 gain_chan
);
	import qbcg_pkg::*;

	localparam int SQ_N = ROOT_W;
	localparam int DV_N = QUO_W;

	logic en;
	logic out_valid_q;
	logic [ONE_W-1:0] fin_q;
	logic [ONE_W-1:0] fout_q;

	// root stages, one result bit each
	logic sq_v_s [0:SQ_N];
	logic [REM_W-1:0] sq_rem_s [0:SQ_N];
	logic [ROOT_W-1:0] sq_root_s [0:SQ_N];
	logic [ONE_W-1:0] sq_x_s [0:SQ_N];

	// divide stages, one quotient bit each
	logic dv_v_s [0:DV_N];
	logic [NUM_W-1:0] dv_rem_s [0:DV_N];
	logic [DEN_W-1:0] dv_den_s [0:DV_N];
	logic [QUO_W-1:0] dv_q_s [0:DV_N];

	logic [DEN_W-1:0] den;
	logic [ONE_W-1:0] t;
	logic v_s1, v_s2, v_s3;
	logic [MUL_W-1:0] p_s1;
	logic [ONE_W-1:0] t_s1;
	logic [ONE_W-1:0] u_s2;
	logic [MUL_W-1:0] tt_s2;
	logic [MUL_W-1:0] tt_s3;
	logic [MUL_W-1:0] m_s3;
	logic [MUL_W-1:0] u_sum;
	logic [MUL_W:0] y_sum;
	logic [MUL_W:0] y_sh;
	logic [ONE_W-1:0] y;

	assign en = !out_valid_q || gain_chan.ready;
	assign pop = en && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0] <= REM_W'(head.disc);
			sq_root_s[0] <= '0;
			sq_x_s[0] <= head.x;
		end
	end

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		localparam int I = SQ_N - 1 - k;
		logic [REM_W-1:0] trial;
		logic ge;
		assign trial = (REM_W'(sq_root_s[k]) << (I + 1)) + (REM_W'(1) << (2 * I));
		assign ge = sq_rem_s[k] >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[k+1] <= ge ? sq_rem_s[k] - trial : sq_rem_s[k];
				sq_root_s[k+1] <= ge ? (sq_root_s[k] | (ROOT_W'(1) << I)) : sq_root_s[k];
				sq_x_s[k+1] <= sq_x_s[k];
			end
		end
	end

	// t = round((x << F) / (cx + s))
	assign den = DEN_W'(cx) + DEN_W'(sq_root_s[SQ_N]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= {sq_x_s[SQ_N], {FRAC_BITS{1'b0}}} + NUM_W'(den >> 1);
			dv_den_s[0] <= den;
			dv_q_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < DV_N; k++) begin : g_dv
		localparam int I = DV_N - 1 - k;
		logic [DSH_W-1:0] dsh;
		logic ge;
		assign dsh = DSH_W'(dv_den_s[k]) << I;
		assign ge = DSH_W'(dv_rem_s[k]) >= dsh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k+1] <= ge ? dv_rem_s[k] - dsh[NUM_W-1:0] : dv_rem_s[k];
				dv_den_s[k+1] <= dv_den_s[k];
				dv_q_s[k+1] <= ge ? (dv_q_s[k] | (QUO_W'(1) << I)) : dv_q_s[k];
			end
		end
	end

	assign t = (dv_q_s[DV_N] > QUO_W'(ONE)) ? ONE : dv_q_s[DV_N][ONE_W-1:0];
	assign u_sum = (p_s1 + MUL_W'(HALF)) >> FRAC_BITS;
	assign y_sum = (MUL_W+1)'(m_s3) + (MUL_W+1)'(tt_s3) + (MUL_W+1)'(HALF);
	assign y_sh = y_sum >> FRAC_BITS;
	assign y = (y_sh > (MUL_W+1)'(ONE)) ? ONE : y_sh[ONE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= dv_v_s[DV_N];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// u = (1-t)t, then y = 2u*cy + t^2
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= MUL_W'(ONE - t) * MUL_W'(t);
			t_s1 <= t;
			u_s2 <= u_sum[ONE_W-1:0];
			tt_s2 <= MUL_W'(t_s1) * MUL_W'(t_s1);
			m_s3 <= (MUL_W'(u_s2) * MUL_W'(cy)) << 1;
			tt_s3 <= tt_s2;
			fin_q <= y;
			fout_q <= ONE - y;
		end
	end

	assign gain_chan.valid = out_valid_q;
	assign gain_chan.fade_in_gain = fin_q;
	assign gain_chan.fade_out_gain = fout_q;
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
	import qbcg_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CP_W-1:0] cfg_data;

	qbcg_pos_if pos_chan();
	qbcg_gain_if gain_chan();

	quadratic_bezier_crossfade_gain dut (
		.clk(clk),
		.arst_n(arst_n),
		.pos_chan(pos_chan.sink),
		.gain_chan(gain_chan.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct {
		logic [ONE_W-1:0] fade_in;
		logic [ONE_W-1:0] fade_out;
	} gain_pair_t;

	// predictor's own copy of the control points
	logic [CP_W-1:0] curve_cx;
	logic [CP_W-1:0] curve_cy;
	gain_pair_t pending_gains[$];
	int fail_count;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// clamp on write, as the block does
	function automatic logic [CP_W-1:0] clamp_point(input logic [CP_W-1:0] v);
		if (v < LO_CLAMP) return LO_CLAMP;
		if (v > HI_CLAMP) return HI_CLAMP;
		return v;
	endfunction

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// curve evaluation for one position
	function automatic gain_pair_t curve_gain(input logic [ONE_W-1:0] pos);
		longint unsigned x, cx, cy, abs_a, t, u, y, den, s;
		longint a, d;
		gain_pair_t g;
		x = pos;
		cx = curve_cx;
		cy = curve_cy;
		if (x > (64'd1 << FRAC_BITS)) x = 64'd1 << FRAC_BITS;
		a = longint'(64'd1 << FRAC_BITS) - 2 * longint'(cx);
		abs_a = (a < 0) ? longint'(-a) : longint'(a);
		if (abs_a * 1000000 < (64'd1 << FRAC_BITS)) begin
			den = 2 * cx;
		end else begin
			d = longint'(cx * cx) + a * longint'(x);
			s = (d > 0) ? isqrt(d) : 0;
			den = cx + s;
		end
		t = ((x << FRAC_BITS) + den / 2) / den;
		if (t > (64'd1 << FRAC_BITS)) t = 64'd1 << FRAC_BITS;
		u = (((64'd1 << FRAC_BITS) - t) * t + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		y = (2 * u * cy + t * t + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (y > (64'd1 << FRAC_BITS)) y = 64'd1 << FRAC_BITS;
		g.fade_in = y[ONE_W-1:0];
		g.fade_out = ONE - y[ONE_W-1:0];
		return g;
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		gain_pair_t want;
		if (arst_n) begin
			if (gain_chan.valid && gain_chan.ready) begin
				if (pending_gains.size() == 0) begin
					$error("unexpected result in=%0d", gain_chan.fade_in_gain);
					fail_count++;
				end else begin
					want = pending_gains.pop_front();
					if (gain_chan.fade_in_gain !== want.fade_in) begin
						$error("fade_in_gain expected %0d actual %0d", want.fade_in,
							gain_chan.fade_in_gain);
						fail_count++;
					end
					if (gain_chan.fade_out_gain !== want.fade_out) begin
						$error("fade_out_gain expected %0d actual %0d", want.fade_out,
							gain_chan.fade_out_gain);
						fail_count++;
					end
				end
			end
			gain_chan.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((pos_chan.valid && pos_chan.ready) || (gain_chan.valid && gain_chan.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// one position transfer, expectation queued when accepted
	// valid stays up after the transfer until the next offer or a drain
	task automatic send_position(input logic [ONE_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			pos_chan.valid <= 1'b0;
			@(posedge clk);
		end
		pos_chan.valid <= 1'b1;
		pos_chan.position <= pos;
		@(posedge clk);
		while (!pos_chan.ready) @(posedge clk);
		pending_gains.push_back(curve_gain(pos));
	endtask

	task automatic drain;
		pos_chan.valid <= 1'b0;
		while (pending_gains.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_point(input reg_idx_t idx, input logic [CP_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CONTROL_X) curve_cx = clamp_point(v);
		else curve_cy = clamp_point(v);
	endtask

	// random positions, mostly in range, some above one
	task automatic send_random(input int n);
		logic [ONE_W-1:0] p;
		repeat (n) begin
			if ($urandom_range(9) == 0) p = ONE_W'($urandom_range(131071));
			else p = ONE_W'($urandom_range(65536));
			send_position(p);
		end
	endtask

	task automatic test_directed;
		logic [ONE_W-1:0] pts[$];
		pts = '{0, 1, 2, 32768, 65535, 65536, 65537, 131071, 100000, 16384, 49152};
		foreach (pts[i]) send_position(pts[i]);
		drain();
		// extremes of the control point, with clamping below and above
		write_point(REG_CONTROL_X, 16'd0);
		write_point(REG_CONTROL_Y, 16'hffff);
		foreach (pts[i]) if (i < 6) send_position(pts[i]);
		drain();
		write_point(REG_CONTROL_X, 16'hffff);
		write_point(REG_CONTROL_Y, 16'd0);
		foreach (pts[i]) if (i < 6) send_position(pts[i]);
		drain();
	endtask

	task automatic test_random_configs;
		logic [CP_W-1:0] pts[$];
		pts = '{LO_CLAMP, HI_CLAMP, 16'd32768, 16'd32767, 16'd32769};
		for (int ph = 0; ph < 12; ph++) begin
			unique case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			if (ph < 5) write_point(REG_CONTROL_X, pts[ph]);
			else write_point(REG_CONTROL_X, CP_W'($urandom));
			write_point(REG_CONTROL_Y, (ph % 3 == 0) ? pts[ph % 2] : CP_W'($urandom));
			send_random(110);
			drain();
		end
	endtask

	// receiver held off while the sender keeps offering
	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_random(100);
				pos_chan.valid <= 1'b0;
			end
		join
		drain();
		// sender pauses until all results are in, then resumes
		send_random(50);
		drain();
		send_random(50);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		pos_chan.valid = 1'b0;
		pos_chan.position = '0;
		gain_chan.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CONTROL_X;
		cfg_data = '0;
		fail_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		curve_cx = CP_RESET;
		curve_cy = CP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_configs();
		test_backpressure();
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
